FILE: sv/radix_prefixed_number_parser_defines.svh
// ----------------------------------------------------------------------------
// Radix-prefixed number parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RADIX_PREFIXED_NUMBER_PARSER_DEFINES_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPNP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpnp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpnp next-cycle check failed");

`endif

FILE: sv/rpnp_pkg.sv
// ----------------------------------------------------------------------------
// rpnp_pkg
// Types, character codes and per-character parse functions for the
// radix-prefixed number parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpnp_pkg;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_BSLASH = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LC_A     = 8'h61;
  localparam logic [7:0] CH_LC_F     = 8'h66;
  localparam logic [7:0] CH_UC_A     = 8'h41;
  localparam logic [7:0] CH_UC_F     = 8'h46;
  localparam logic [7:0] CH_LC_X     = 8'h78;
  localparam logic [7:0] CH_UC_X     = 8'h58;
  localparam logic [7:0] CH_LC_N     = 8'h6e;
  localparam logic [7:0] CH_UC_N     = 8'h4e;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  typedef struct packed {
    logic [1:0]  phase;
    logic        decimal;
    logic [63:0] acc;
    logic        digit_seen;
    logic        bad_seen;
    logic        ovf_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_START, decimal: 1'b0, acc: 64'd0,
    digit_seen: 1'b0, bad_seen: 1'b0, ovf_seen: 1'b0
  };

  // Applies one character that follows the prefix.
  function automatic state_t body_char(state_t s, logic [7:0] c);
    state_t      n;
    logic        is_num;
    logic        is_hex;
    logic [3:0]  d;
    logic [67:0] dec;
    n      = s;
    is_num = (c >= CH_ZERO) && (c <= CH_NINE);
    is_hex = !s.decimal && (((c >= CH_LC_A) && (c <= CH_LC_F)) ||
                            ((c >= CH_UC_A) && (c <= CH_UC_F)));
    d      = is_num ? c[3:0] : (c[3:0] + 4'd9);
    dec    = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {64'd0, d};
    if (c == CH_BACKTICK) begin
      n = s;
    end else if (!is_num && !is_hex) begin
      n.bad_seen = 1'b1;
    end else begin
      n.digit_seen = 1'b1;
      if (s.decimal) begin
        if (!s.ovf_seen) begin
          if (dec[67:64] != 4'd0) begin
            n.ovf_seen = 1'b1;
          end else begin
            n.acc = dec[63:0];
          end
        end
      end else if (s.ovf_seen || (s.acc[63:60] != 4'd0)) begin
        n.ovf_seen = 1'b1;
        n.acc      = '1;
      end else begin
        n.acc = {s.acc[59:0], d};
      end
    end
    return n;
  endfunction

  // A pending zero or backslash that was not followed by a radix letter.
  function automatic state_t resolve_pending(state_t s);
    state_t n;
    n         = s;
    n.decimal = 1'b0;
    if (s.phase == PH_ZERO) begin
      n = body_char(n, CH_ZERO);
    end else if (s.phase == PH_BSLASH) begin
      n.bad_seen = 1'b1;
    end
    n.phase = PH_BODY;
    return n;
  endfunction

  // Applies one raw character of the string.
  function automatic state_t take_char(state_t s, logic [7:0] c);
    state_t n;
    logic   hex_letter;
    logic   dec_letter;
    n          = s;
    hex_letter = (c == CH_LC_X) || (c == CH_UC_X);
    dec_letter = (c == CH_LC_N) || (c == CH_UC_N);
    case (s.phase)
      PH_START: begin
        if (c == CH_ZERO) begin
          n.phase = PH_ZERO;
        end else if (c == CH_BSLASH) begin
          n.phase = PH_BSLASH;
        end else if (hex_letter || dec_letter) begin
          n.phase   = PH_BODY;
          n.decimal = dec_letter;
        end else begin
          n.phase   = PH_BODY;
          n.decimal = 1'b0;
          n         = body_char(n, c);
        end
      end
      PH_ZERO, PH_BSLASH: begin
        if (hex_letter || dec_letter) begin
          n.phase   = PH_BODY;
          n.decimal = dec_letter;
        end else begin
          n = body_char(resolve_pending(s), c);
        end
      end
      default: begin
        n = body_char(s, c);
      end
    endcase
    return n;
  endfunction

endpackage

FILE: sv/radix_prefixed_number_parser.sv
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser
// Parses an ASCII string, one character per beat, into a 64-bit value with
// an optional hexadecimal or decimal radix prefix.
// ----------------------------------------------------------------------------
//  Channel   Ports                                       Direction
//  input     in_valid/in_ready, char_code, flags         into the block
//  result    out_valid/out_ready, parsed_value, ok       out of the block
//
// Each beat is captured in an input register and then applied to the parse
// state; a beat that ends a string loads the result register from it. One
// beat per cycle is sustained unless a held result stalls. Reset returns
// the parse state to the start of a string. A held result stalls only a
// beat that ends a string; other beats keep flowing into the parse state.
`timescale 1ns / 1ps

`include "radix_prefixed_number_parser_defines.svh"

module radix_prefixed_number_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_no_char,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_parsed_value,
  output logic        out_parse_ok
);
  import rpnp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_none_r;
  logic        s1_last_r;
  state_t      st_r;
  state_t      st_nxt;
  state_t      st_char;
  state_t      st_end;
  logic        s1_go;
  logic        res_load;
  logic        res_ok;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_ok_r;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign res_load = s1_go && s1_last_r;
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    st_char = s1_none_r ? st_r : take_char(st_r, s1_char_r);
    st_end  = ((st_char.phase == PH_ZERO) || (st_char.phase == PH_BSLASH)) ?
              resolve_pending(st_char) : st_char;
    res_ok  = st_end.digit_seen && !st_end.bad_seen &&
              !(st_end.decimal && st_end.ovf_seen);
    st_nxt  = st_r;
    if (s1_go) begin
      st_nxt = s1_last_r ? STATE_RESET : st_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      st_r <= st_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_none_r <= in_no_char;
      s1_last_r <= in_last_char;
    end
    if (res_load) begin
      out_value_r <= res_ok ? st_end.acc : 64'd0;
      out_ok_r    <= res_ok;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_value_r;
  assign out_parse_ok     = out_ok_r;

  `RPNP_ASSERT_IMPL(a_invalid_is_zero, out_valid && !out_parse_ok, out_parsed_value == 64'd0)
  `RPNP_ASSERT_NEXT(a_end_clears_state, res_load, (st_r.phase == PH_START) && !st_r.digit_seen)
  `RPNP_ASSERT_IMPL(a_empty_stage_ready, !s1_valid_r, in_ready)
  `RPNP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_parse_ok))

endmodule
